### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition c in the same cycle
`define GSD_ASSERT_NOW(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// condition a implies condition c in the following cycle
`define GSD_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

### src/gsd_pkg.sv
package gsd_pkg;

   localparam int MAX_GROUP = 4096;

   localparam int SAMPLE_W = 16;
   localparam int STD_W = 20;
   localparam int STATUS_W = 2;

   localparam int COUNT_W = $clog2(MAX_GROUP + 1);
   localparam int SQUARE_W = 2 * SAMPLE_W - 1;
   localparam int SUM_W = SAMPLE_W + COUNT_W - 1;
   localparam int SQ_W = SQUARE_W + COUNT_W - 1;
   localparam int SQ_LO_W = SQ_W / 2;
   localparam int SQ_HI_W = SQ_W - SQ_LO_W;
   localparam int MAG_W = SUM_W;
   localparam int NUM_W = COUNT_W + SQ_W;
   localparam int DEN_W = 2 * COUNT_W;
   localparam int FRAC_SHIFT = 8;
   localparam int DIVIDEND_W = NUM_W + FRAC_SHIFT;
   localparam int ROOT_W = (DIVIDEND_W + 1) / 2;
   localparam int ROOT_REM_W = ROOT_W + 2;
   localparam int STEP_W = $clog2(DIVIDEND_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic last_in_group;
   } req_type;

   typedef struct packed {
      logic [STD_W-1:0] std_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // finished group totals handed from front to back
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0] square_sum;
      logic overflow;
      logic unbiased;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL_LO,
      B_MUL_HI,
      B_SUB,
      B_DIV,
      B_SQRT,
      B_DONE
   } back_state_type;

endpackage

### src/gsd_front.sv
module gsd_front
   import gsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   input  logic      unbiased,
   output logic      push,
   output group_type group
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic ovf_ff, ovf_in;

   logic take;
   logic signed [2*SAMPLE_W-1:0] product;
   logic [COUNT_W-1:0] count_next;
   logic signed [SUM_W-1:0] sum_next;
   logic [SQ_W-1:0] sq_next;
   logic ovf_next;

   always_comb begin
      take = count_ff < COUNT_W'(MAX_GROUP);
      product = req.sample * req.sample;
      count_next = take ? count_ff + COUNT_W'(1) : count_ff;
      sum_next = take ? sum_ff + SUM_W'(req.sample) : sum_ff;
      sq_next = take ? sq_ff + SQ_W'(product[SQUARE_W-1:0]) : sq_ff;
      ovf_next = ovf_ff | ~take;

      push = accept & req.last_in_group;
      group.count = count_next;
      group.sum = sum_next;
      group.square_sum = sq_next;
      group.overflow = ovf_next;
      group.unbiased = unbiased;

      count_in = count_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req.last_in_group) begin
            count_in = '0;
            sum_in = '0;
            sq_in = '0;
            ovf_in = 1'b0;
         end else begin
            count_in = count_next;
            sum_in = sum_next;
            sq_in = sq_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

### src/gsd_queue.sv
module gsd_queue
   import gsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  group_type        group_in,
   input  logic             pop,
   output group_type        group_out,
   output queue_status_type status
);

   group_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      status.full = fill_ff == QCOUNT_W'(QUEUE_DEPTH);
      status.empty = fill_ff == '0;
      group_out = entry_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10: fill_in = fill_ff + QCOUNT_W'(1);
         2'b01: fill_in = fill_ff - QCOUNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= group_in;
      end
   end

endmodule

### src/gsd_back.sv
module gsd_back
   import gsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  group_type        group,
   output logic             pop,
   output logic             rsp_strobe,
   output rsp_type          rsp_payload
);

   back_state_type state_ff, state_in;

   logic [COUNT_W-1:0] n_ff, n_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [SQ_W-1:0] sumsq_ff, sumsq_in;
   logic ovf_ff, ovf_in;
   logic [NUM_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0] msq_ff, msq_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_REM_W-1:0] rrem_ff, rrem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rsp_type result_ff, result_in;

   logic too_few;
   logic [MAG_W-1:0] mag_load;
   logic [COUNT_W-1:0] d_factor;
   logic [DEN_W:0] div_trial;
   logic [ROOT_REM_W+1:0] sq_trial;
   logic [ROOT_REM_W+1:0] sq_cand;
   logic [NUM_W-1:0] num;
   logic last_div_step;
   logic last_sqrt_step;

   always_comb begin
      too_few = (group.count == '0) || (group.unbiased && group.count == COUNT_W'(1));
      last_div_step = step_ff == STEP_W'(DIVIDEND_W - 1);
      last_sqrt_step = step_ff == STEP_W'(ROOT_W - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               state_in = too_few ? B_DONE : B_MUL_LO;
            end
         end
         B_MUL_LO: state_in = B_MUL_HI;
         B_MUL_HI: state_in = B_SUB;
         B_SUB: state_in = B_DIV;
         B_DIV: begin
            if (last_div_step) begin
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (last_sqrt_step) begin
               state_in = B_DONE;
            end
         end
         B_DONE: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in = n_ff;
      mag_in = mag_ff;
      sumsq_in = sumsq_ff;
      ovf_in = ovf_ff;
      prod_in = prod_ff;
      msq_in = msq_ff;
      den_in = den_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rrem_in = rrem_ff;
      step_in = step_ff;
      result_in = result_ff;

      mag_load = group.sum[SUM_W-1] ? MAG_W'(-group.sum) : MAG_W'(group.sum);
      d_factor = group.unbiased ? group.count - COUNT_W'(1) : group.count;
      num = prod_ff - msq_ff;
      div_trial = {rem_ff, work_ff[DIVIDEND_W-1]};
      sq_trial = {rrem_ff, work_ff[DIVIDEND_W-1 -: 2]};
      sq_cand = (ROOT_REM_W + 2)'({root_ff, 2'b01});

      pop = (state_ff == B_IDLE) && !q_status.empty;
      rsp_strobe = state_ff == B_DONE;
      rsp_payload = result_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               n_in = group.count;
               mag_in = mag_load;
               sumsq_in = group.square_sum;
               ovf_in = group.overflow;
               // n * d only depends on the queued entry
               den_in = DEN_W'(group.count) * DEN_W'(d_factor);
               result_in.std_value = '0;
               result_in.status = STATUS_FEW;
            end
         end
         B_MUL_LO: begin
            prod_in = NUM_W'(n_ff) * NUM_W'(sumsq_ff[SQ_LO_W-1:0]);
            msq_in = NUM_W'(mag_ff) * NUM_W'(mag_ff);
         end
         B_MUL_HI: begin
            prod_in = prod_ff
                    + ((NUM_W'(n_ff) * NUM_W'(sumsq_ff[SQ_W-1:SQ_LO_W])) << SQ_LO_W);
         end
         B_SUB: begin
            work_in = {num, FRAC_SHIFT'(0)};
            rem_in = '0;
            step_in = '0;
         end
         B_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (div_trial >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(div_trial - {1'b0, den_ff});
               work_in = {work_ff[DIVIDEND_W-2:0], 1'b1};
            end else begin
               rem_in = div_trial[DEN_W-1:0];
               work_in = {work_ff[DIVIDEND_W-2:0], 1'b0};
            end
            step_in = last_div_step ? '0 : step_ff + STEP_W'(1);
            root_in = '0;
            rrem_in = '0;
         end
         B_SQRT: begin
            // digit recurrence, two radicand bits per cycle
            work_in = {work_ff[DIVIDEND_W-3:0], 2'b00};
            if (sq_trial >= sq_cand) begin
               rrem_in = ROOT_REM_W'(sq_trial - sq_cand);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rrem_in = sq_trial[ROOT_REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (last_sqrt_step) begin
               result_in.std_value = root_in[STD_W-1:0];
               result_in.status = ovf_ff ? STATUS_OVER : STATUS_OK;
            end
         end
         B_DONE: begin
            step_in = '0;
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      mag_ff <= mag_in;
      sumsq_ff <= sumsq_in;
      ovf_ff <= ovf_in;
      prod_ff <= prod_in;
      msq_ff <= msq_in;
      den_ff <= den_in;
      work_ff <= work_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      result_ff <= result_in;
   end

endmodule

### src/group_standard_deviation_unit.sv
// Group standard deviation. Samples are taken one per cycle while start is high
// and busy is low; the last sample of a group (last_in_group) closes it. With
// the back end free, the result shows on rsp_payload with rsp_strobe high for
// exactly one cycle, in B_DONE, reached from B_IDLE through B_MUL_LO, B_MUL_HI,
// B_SUB, B_DIV and B_SQRT (straight from B_IDLE for a group with too few
// samples). There is no back-pressure on the result side: a result must be
// captured in the cycle its strobe is high. Each group's totals wait in a
// two-entry queue for the back end, whose multiply steps, bit-serial divider
// and bit-serial square root work on one group at a time; busy is high while
// that queue is full, so a stream of groups that outpaces the back end stalls
// on it. std_value is floor(16 * sqrt(variance)); status reports too few
// samples or a group longer than 4096 samples, whose extra samples are dropped.
// csr_write_data selects the divisor (1 for count minus one, 0 for count) and
// is taken for a group when its last sample is accepted.
`include "assert_macros.svh"

module group_standard_deviation_unit
   import gsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic unbiased_ff, unbiased_in;
   logic accept;
   logic push;
   logic pop;
   group_type front_group;
   group_type queue_group;
   queue_status_type q_status;

   always_comb begin
      unbiased_in = csr_write_enable ? csr_write_data : unbiased_ff;
      busy = q_status.full;
      accept = start && !busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unbiased_ff <= 1'b0;
      end else begin
         unbiased_ff <= unbiased_in;
      end
   end

   gsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .unbiased (unbiased_ff),
      .push     (push),
      .group    (front_group)
   );

   gsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .group_in  (front_group),
      .pop       (pop),
      .group_out (queue_group),
      .status    (q_status)
   );

   gsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .group       (queue_group),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   `GSD_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe held")
   `GSD_ASSERT_NEXT(a_last_queued, clock, reset, accept && req_payload.last_in_group, !q_status.empty, "closed group not queued")
   `GSD_ASSERT_NOW(a_status_code, clock, reset, rsp_strobe, rsp_payload.status == STATUS_OK || rsp_payload.status == STATUS_FEW || rsp_payload.status == STATUS_OVER, "bad status code")
   `GSD_ASSERT_NOW(a_few_zero, clock, reset, rsp_strobe && rsp_payload.status == STATUS_FEW, rsp_payload.std_value == '0, "nonzero value with too few samples")

endmodule
